>>> hdl/rmst_pkg.sv
// Shared types and constants of the range maximum segment tree core.
package rmst_pkg;

   localparam int MODE_W          = 2;
   localparam int POSITION_W      = 10;
   localparam int IN_VALUE_W      = 32;
   localparam int RANGE_W         = 11;
   localparam int LEAF_COUNT_W    = 11;
   localparam int RESULT_W        = 31;
   localparam logic [LEAF_COUNT_W-1:0] LEAF_COUNT_RESET = 11'd1024;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_SET   = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SET_LEAF,
      ST_SET_UP,
      ST_QUERY,
      ST_FINISH
   } state_type;

endpackage

>>> hdl/range_max_segment_tree_core.sv
// Range maximum segment tree: a tree store in one synchronous memory walked by a sequencer.
// After reset the core sweeps the whole tree store to zero, one entry per cycle, with req_stall
// high; csr writes are taken during that time. Items are then handled one at a time through the
// single registered memory read port. A set in range writes its leaf and then climbs one tree
// level per cycle; a query reads at most two nodes per tree level. A clear writes one internal
// node per cycle. The result of an item waits in an output register, so the next item is taken
// while it is stalled.
module range_max_segment_tree_core #(
   parameter int MAX_LEAVES  = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [rmst_pkg::MODE_W-1:0]           req_mode,
   input  logic [rmst_pkg::POSITION_W-1:0]       req_position,
   input  logic signed [rmst_pkg::IN_VALUE_W-1:0] req_value,
   input  logic [rmst_pkg::RANGE_W-1:0]          req_range_low,
   input  logic [rmst_pkg::RANGE_W-1:0]          req_range_high,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rmst_pkg::RESULT_W-1:0]         rsp_max_result,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rmst_pkg::LEAF_COUNT_W-1:0]     csr_leaf_count
);
   import rmst_pkg::*;

   localparam int DEPTH  = 2 * MAX_LEAVES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NODE_W = ADDR_W + 1;
   localparam int CMP_W  = (NODE_W > LEAF_COUNT_W) ? NODE_W : LEAF_COUNT_W;
   localparam int EXT_W  = (VALUE_WIDTH > RESULT_W) ? VALUE_WIDTH : RESULT_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [ADDR_W-1:0]      mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;

   state_type state_ff, state_in;
   logic [LEAF_COUNT_W-1:0] leaf_count_ff, leaf_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                    q_pend_ff, q_pend_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic [ADDR_W-1:0]       clr_last_ff, clr_last_in;
   logic [ADDR_W-1:0]       k_ff, k_in;
   logic [VALUE_WIDTH-1:0]  cur_ff, cur_in;
   logic [VALUE_WIDTH-1:0]  best_ff, best_in;
   logic [NODE_W-1:0]       lo_ff, lo_in;
   logic [NODE_W-1:0]       hi_ff, hi_in;
   logic                    ph_ff, ph_in;

   logic [CMP_W-1:0]       lc_ext;
   logic [NODE_W-1:0]      n_leaves;
   logic [CMP_W-1:0]       n_cmp;
   logic [NODE_W-1:0]      lo_clip;
   logic [NODE_W-1:0]      hi_clip;
   logic [NODE_W-1:0]      leaf_node;
   logic [NODE_W-1:0]      lo_p1;
   logic [NODE_W-1:0]      hi_m1;
   logic [ADDR_W-1:0]      k_up;
   logic [VALUE_WIDTH-1:0] up_max;
   logic [VALUE_WIDTH-1:0] fold_max;
   logic [EXT_W-1:0]       best_ext;

   // Tree store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Effective leaf count: zero acts as one, large values saturate.
   always_comb begin
      lc_ext = CMP_W'(leaf_count_ff);
      if (lc_ext == '0) begin
         n_leaves = NODE_W'(1);
      end else if (lc_ext > CMP_W'(MAX_LEAVES)) begin
         n_leaves = NODE_W'(MAX_LEAVES);
      end else begin
         n_leaves = NODE_W'(lc_ext);
      end
   end

   assign n_cmp     = CMP_W'(n_leaves);
   assign lo_clip   = (CMP_W'(req_range_low) > n_cmp) ? n_leaves : NODE_W'(req_range_low);
   assign hi_clip   = (CMP_W'(req_range_high) > n_cmp) ? n_leaves : NODE_W'(req_range_high);
   assign leaf_node = NODE_W'(req_position) + n_leaves;
   assign lo_p1     = lo_ff + NODE_W'(1);
   assign hi_m1     = hi_ff - NODE_W'(1);
   assign k_up      = k_ff >> 1;
   assign up_max    = ($signed(rdata_ff) > $signed(cur_ff)) ? rdata_ff : cur_ff;
   assign fold_max  = ($signed(rdata_ff) > $signed(best_ff)) ? rdata_ff : best_ff;
   // The running maximum starts at zero, so it is never negative here.
   assign best_ext  = EXT_W'(best_ff);

   always_comb begin
      state_in      = state_ff;
      leaf_count_in = leaf_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      q_pend_in     = 1'b0;
      clr_in        = clr_ff;
      clr_last_in   = clr_last_ff;
      k_in          = k_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      ph_in         = ph_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;

      if (csr_valid) begin
         leaf_count_in = csr_leaf_count;
      end

      // Data of a query read issued in the previous cycle is folded in here.
      if (q_pend_ff) begin
         best_in = fold_max;
      end

      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               best_in = '0;
               case (mode_type'(req_mode))
                  MODE_CLEAR: begin
                     clr_in      = ADDR_W'(1);
                     clr_last_in = ADDR_W'(n_leaves - NODE_W'(1));
                     state_in    = (n_leaves > NODE_W'(1)) ? ST_CLEAR : ST_FINISH;
                  end
                  MODE_SET: begin
                     k_in     = ADDR_W'(leaf_node);
                     cur_in   = VALUE_WIDTH'(req_value);
                     state_in = (CMP_W'(req_position) < n_cmp) ? ST_SET_LEAF : ST_FINISH;
                  end
                  MODE_QUERY: begin
                     lo_in    = lo_clip + n_leaves;
                     hi_in    = hi_clip + n_leaves;
                     ph_in    = 1'b0;
                     state_in = ST_QUERY;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == clr_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_SET_LEAF: begin
            mem_we    = 1'b1;
            mem_waddr = k_ff;
            mem_wdata = cur_ff;
            mem_raddr = k_ff ^ ADDR_W'(1);
            state_in  = (k_ff > ADDR_W'(1)) ? ST_SET_UP : ST_FINISH;
         end
         ST_SET_UP: begin
            // The sibling read of the next level never hits the parent written now.
            mem_we    = 1'b1;
            mem_waddr = k_up;
            mem_wdata = up_max;
            mem_raddr = k_up ^ ADDR_W'(1);
            cur_in    = up_max;
            k_in      = k_up;
            if (k_up <= ADDR_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_QUERY: begin
            if (ph_ff) begin
               mem_raddr = ADDR_W'(hi_m1);
               q_pend_in = 1'b1;
               lo_in     = lo_ff >> 1;
               hi_in     = hi_m1 >> 1;
               ph_in     = 1'b0;
            end else if (lo_ff >= hi_ff) begin
               state_in = ST_FINISH;
            end else if (lo_ff[0] && hi_ff[0]) begin
               // Both ends need a node: the right one is read in the next cycle.
               mem_raddr = ADDR_W'(lo_ff);
               q_pend_in = 1'b1;
               lo_in     = lo_p1;
               ph_in     = 1'b1;
            end else if (lo_ff[0]) begin
               mem_raddr = ADDR_W'(lo_ff);
               q_pend_in = 1'b1;
               lo_in     = lo_p1 >> 1;
               hi_in     = hi_ff >> 1;
            end else if (hi_ff[0]) begin
               mem_raddr = ADDR_W'(hi_m1);
               q_pend_in = 1'b1;
               lo_in     = lo_ff >> 1;
               hi_in     = hi_m1 >> 1;
            end else begin
               lo_in = lo_ff >> 1;
               hi_in = hi_ff >> 1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = best_ext[RESULT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         leaf_count_ff <= LEAF_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
         q_pend_ff     <= 1'b0;
         clr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         leaf_count_ff <= leaf_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         q_pend_ff     <= q_pend_in;
         clr_ff        <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      clr_last_ff <= clr_last_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      ph_ff       <= ph_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_max_result = rsp_data_ff;
   assign csr_ready      = 1'b1;

endmodule

>>> hdl/rmst_checker.sv
// Port-level checker for the range maximum segment tree core and its bind.
module rmst_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [rmst_pkg::RESULT_W-1:0]         rsp_max_result
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] open_ff, open_in;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // Items accepted whose result has not been transferred yet.
   always_comb begin
      open_in = open_ff;
      if (req_xfer && !rsp_xfer) begin
         open_in = open_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_max_result))
      else $error("stalled result changed or dropped");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("second item taken in the cycle after a transfer");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("result without an accepted item");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("more than two items in flight");

endmodule

bind range_max_segment_tree_core rmst_checker u_rmst_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_max_result (rsp_max_result)
);

>>> bench/range_max_segment_tree_checker.sv
// Watches the core's channels, keeps its own segment tree and checks every range maximum.
module range_max_segment_tree_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic [rmst_pkg::MODE_W-1:0]             req_mode,
   input  logic [rmst_pkg::POSITION_W-1:0]         req_position,
   input  logic signed [rmst_pkg::IN_VALUE_W-1:0]  req_value,
   input  logic [rmst_pkg::RANGE_W-1:0]            req_range_low,
   input  logic [rmst_pkg::RANGE_W-1:0]            req_range_high,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic [rmst_pkg::RESULT_W-1:0]           rsp_max_result,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [rmst_pkg::LEAF_COUNT_W-1:0]       csr_leaf_count,
   output int                                      mismatch_count,
   output int                                      maxima_waiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import rmst_pkg::*;

   localparam int TREE_LEAVES = 1024;

   logic signed [IN_VALUE_W-1:0] tree_node [0:2*TREE_LEAVES-1];
   logic [LEAF_COUNT_W-1:0]      leaf_count_reg;
   logic [RESULT_W-1:0]          pending_maxima [$];
   logic [RESULT_W-1:0]          oldest_max;
   logic [RESULT_W-1:0]          newest_max;
   int                           mismatches = 0;

   assign mismatch_count = mismatches;

   // A leaf count of zero behaves as one, and counts above the tree size saturate.
   function automatic int leaves_in_use();
      if (leaf_count_reg == 0) return 1;
      if (leaf_count_reg > TREE_LEAVES) return TREE_LEAVES;
      return int'(leaf_count_reg);
   endfunction

   // Applies one transfer to the tree copy and returns the maximum the core must report.
   function automatic logic [RESULT_W-1:0] apply_tree_item(
      input logic [MODE_W-1:0]            mode,
      input logic [POSITION_W-1:0]        position,
      input logic signed [IN_VALUE_W-1:0] value,
      input logic [RANGE_W-1:0]           range_low,
      input logic [RANGE_W-1:0]           range_high
   );
      int                           n;
      int                           node;
      int                           lo;
      int                           hi;
      logic signed [IN_VALUE_W-1:0] best;
      n = leaves_in_use();
      best = '0;
      case (mode)
         MODE_CLEAR: begin
            for (node = 1; node < n; node++) tree_node[node] = '0;
         end
         MODE_SET: begin
            if (int'(position) < n) begin
               node = int'(position) + n;
               tree_node[node] = value;
               while (node > 1) begin
                  tree_node[node >> 1] = (tree_node[node ^ 1] > tree_node[node]) ?
                                         tree_node[node ^ 1] : tree_node[node];
                  node = node >> 1;
               end
            end
         end
         MODE_QUERY: begin
            lo = int'(range_low);
            hi = int'(range_high);
            if (lo > n) lo = n;
            if (hi > n) hi = n;
            lo += n;
            hi += n;
            while (lo < hi) begin
               if (lo & 1) begin
                  if (tree_node[lo] > best) best = tree_node[lo];
                  lo++;
               end
               if (hi & 1) begin
                  hi--;
                  if (tree_node[hi] > best) best = tree_node[hi];
               end
               lo = lo >> 1;
               hi = hi >> 1;
            end
         end
         default: ;
      endcase
      return best[RESULT_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2*TREE_LEAVES; i++) tree_node[i] = '0;
         leaf_count_reg = LEAF_COUNT_RESET;
         pending_maxima.delete();
      end else begin
         // Results leave before a new transfer is added, so a same-cycle pair stays in order.
         if (rsp_valid && !rsp_stall) begin
            if (pending_maxima.size() == 0) begin
               $display("%0t: max_result %0d arrived with nothing expected",
                        $time, rsp_max_result);
               mismatches++;
            end else begin
               oldest_max = pending_maxima.pop_front();
               if (rsp_max_result !== oldest_max) begin
                  $display("%0t: max_result mismatch, expected %0d, actual %0d",
                           $time, oldest_max, rsp_max_result);
                  mismatches++;
               end
            end
         end
         // An item taken in the same cycle as a register write still sees the old leaf count.
         if (req_valid && !req_stall) begin
            newest_max = apply_tree_item(req_mode, req_position, req_value,
                                         req_range_low, req_range_high);
            pending_maxima = {pending_maxima, newest_max};
         end
         if (csr_valid && csr_ready) leaf_count_reg = csr_leaf_count;
      end
      maxima_waiting <= pending_maxima.size();
   end

endmodule

>>> bench/range_max_segment_tree_core_tb.sv
// Stimulus, flow control and verdict for the range maximum segment tree core.
module range_max_segment_tree_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rmst_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int PHASE_ITEMS    = 120;
   localparam int PRESSURE_PHASE = 4;
   localparam int PHASE_COUNT    = 11;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [MODE_W-1:0]             req_mode;
   logic [POSITION_W-1:0]         req_position;
   logic signed [IN_VALUE_W-1:0]  req_value;
   logic [RANGE_W-1:0]            req_range_low;
   logic [RANGE_W-1:0]            req_range_high;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [RESULT_W-1:0]           rsp_max_result;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [LEAF_COUNT_W-1:0]       csr_leaf_count;
   int                            mismatch_count;
   int                            maxima_waiting;

   bit idle_enabled = 1'b1;
   bit hold_responses = 1'b0;
   int leaves_in_use = 1024;
   int phase_leaves [PHASE_COUNT] = '{0, 1, 2, 3, 16, 100, 517, 1023, 2047, 7, 1024};

   range_max_segment_tree_core dut (.*);

   range_max_segment_tree_checker tree_check (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #20_000_000;
      $display("range_max_segment_tree_core regression: fail");
      $finish;
   end

   // Holds the result channel back in bursts, or for one long stretch when asked to.
   initial begin
      forever begin
         if (hold_responses) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_responses = 1'b0;
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Valid stays high after a transfer; it only drops for an idle burst or a drain.
   task automatic offer_item(
      input logic [MODE_W-1:0]            mode,
      input logic [POSITION_W-1:0]        position,
      input logic signed [IN_VALUE_W-1:0] value,
      input logic [RANGE_W-1:0]           range_low,
      input logic [RANGE_W-1:0]           range_high
   );
      int gap;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_position   <= position;
      req_value      <= value;
      req_range_low  <= range_low;
      req_range_high <= range_high;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (maxima_waiting != 0);
   endtask

   task automatic write_leaf_count(input logic [LEAF_COUNT_W-1:0] count);
      csr_valid      <= 1'b1;
      csr_leaf_count <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      leaves_in_use = (count == 0) ? 1 : (count > 1024) ? 1024 : int'(count);
   endtask

   // Mostly sets inside the leaves and queries over real ranges, with some noise mixed in.
   task automatic offer_random_item();
      logic [MODE_W-1:0]            mode;
      logic [POSITION_W-1:0]        position;
      logic signed [IN_VALUE_W-1:0] value;
      logic [RANGE_W-1:0]           lo;
      logic [RANGE_W-1:0]           hi;
      int                           pick;
      int                           a;
      int                           b;
      pick     = $urandom_range(0, 99);
      position = POSITION_W'($urandom);
      value    = $urandom;
      lo       = RANGE_W'($urandom);
      hi       = RANGE_W'($urandom);
      if (pick < 3) begin
         mode = MODE_CLEAR;
      end else if (pick < 5) begin
         mode = MODE_SPARE;
      end else if (pick < 52) begin
         mode = MODE_SET;
         if ($urandom_range(0, 7) != 0) begin
            position = POSITION_W'($urandom_range(0, leaves_in_use - 1));
         end
         case ($urandom_range(0, 5))
            0: value = $urandom_range(0, 1000);
            1: value = -int'($urandom_range(1, 1000));
            2: value = 32'h7FFF_FFFF;
            3: value = 32'h8000_0000;
            4: value = $urandom & 32'h7FFF_FFFF;
            default: ;
         endcase
      end else begin
         mode = MODE_QUERY;
         a = $urandom_range(0, leaves_in_use);
         b = $urandom_range(0, leaves_in_use);
         case ($urandom_range(0, 7))
            0: ;
            1, 2: begin
               lo = RANGE_W'(a);
               hi = RANGE_W'(a + int'($urandom_range(0, 3)));
            end
            default: begin
               lo = RANGE_W'((a < b) ? a : b);
               hi = RANGE_W'((a < b) ? b : a);
            end
         endcase
      end
      offer_item(mode, position, value, lo, hi);
   endtask

   initial begin
      req_valid      <= 1'b0;
      req_mode       <= '0;
      req_position   <= '0;
      req_value      <= '0;
      req_range_low  <= '0;
      req_range_high <= '0;
      csr_valid      <= 1'b0;
      csr_leaf_count <= '0;
      reset          <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items on the reset leaf count of 1024.
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd0, 11'd1024);
      offer_item(MODE_SET, 10'd0, 32'h7FFF_FFFF, 11'd0, 11'd0);
      offer_item(MODE_SET, 10'd1023, 32'h8000_0000, 11'd0, 11'd0);
      offer_item(MODE_SET, 10'd512, -32'sd1, 11'd0, 11'd0);
      offer_item(MODE_SET, 10'd5, 32'sd12345, 11'd0, 11'd0);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd0, 11'd1024);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd1023, 11'd1024);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd1, 11'd1024);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd5, 11'd6);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd10, 11'd3);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd7, 11'd7);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd2047, 11'd2047);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd0, 11'd2047);
      offer_item(MODE_SPARE, 10'h3FF, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF);
      offer_item(MODE_CLEAR, 10'd0, 32'sd0, 11'd0, 11'd0);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd1, 11'd1024);
      offer_item(MODE_SET, 10'd6, 32'sd99, 11'd0, 11'd0);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd0, 11'd1024);
      offer_item(MODE_SET, 10'd0, 32'sd0, 11'd0, 11'd0);
      offer_item(MODE_QUERY, 10'd0, 32'sd0, 11'd0, 11'd1024);
      drain_results();

      // One leaf count per phase; the last phase runs without any idling.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_leaf_count(LEAF_COUNT_W'(phase_leaves[p]));
         idle_enabled = (p != PHASE_COUNT - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == PRESSURE_PHASE && i == 40) hold_responses = 1'b1;
            if (p == PRESSURE_PHASE && i == 80) drain_results();
            offer_random_item();
         end
         drain_results();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("range_max_segment_tree_core regression: pass");
      end else begin
         $display("range_max_segment_tree_core regression: fail");
      end
      $finish;
   end

endmodule
